### hw/rtl/sparse_delta_matrix_decoder_defines.svh
// Assertion macros for the sparse delta matrix decoder.
// Expects clk and arst_n in the scope of each use.
`ifndef SPARSE_DELTA_MATRIX_DECODER_DEFINES_SVH
`define SPARSE_DELTA_MATRIX_DECODER_DEFINES_SVH

// Check cons in the same cycle as ante.
`define SDMD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define SDMD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/sdmd_pkg.sv
// Shared types, constants and the code length table of the sparse delta matrix decoder.
// No dependencies.
`timescale 1ns / 1ps

package sdmd_pkg;

	localparam int POS_BITS    = 48;
	localparam int VAL_BITS    = 64;
	localparam int DELTA_BITS  = 45;
	localparam int CODE_MAX    = 14;
	localparam int TAB_ENTRIES = 256;
	localparam int GROUP_ROWS  = 16;
	localparam int GROW_BITS   = $clog2(GROUP_ROWS);
	localparam int CNT_BITS    = $clog2(CODE_MAX + 1);

	typedef enum logic {
		CMD_STREAM = 1'b0,
		CMD_TABLE  = 1'b1
	} sdmd_cmd_t;

	typedef enum logic [2:0] {
		OP_ADVANCE = 3'd0,
		OP_TAB_D5  = 3'd1,
		OP_TAB_D13 = 3'd2,
		OP_TAB_D29 = 3'd3,
		OP_TAB_D45 = 3'd4,
		OP_LIT_D5  = 3'd5,
		OP_LIT_D21 = 3'd6,
		OP_LIT_D45 = 3'd7
	} sdmd_op_t;

	typedef struct packed {
		sdmd_cmd_t               cmd;
		logic [7:0]              data_byte;
		logic                    end_of_block;
		logic [POS_BITS-1:0]     block_rows;
		logic [7:0]              table_index;
		logic [VAL_BITS-1:0]     table_value;
	} sdmd_in_t;

	typedef struct packed {
		logic [POS_BITS-1:0]     row_index;
		logic [POS_BITS-1:0]     col_index;
		logic [VAL_BITS-1:0]     value_bits;
	} sdmd_out_t;

	// decoded nonzero, before the row offset add and the table lookup
	typedef struct packed {
		logic [POS_BITS-1:0]     row_base;
		logic [POS_BITS-1:0]     offset;
		logic [POS_BITS-1:0]     col;
		logic [VAL_BITS-1:0]     literal;
		logic                    use_table;
	} sdmd_hit_t;

	typedef struct packed {
		logic                    en;
		logic [7:0]              addr;
	} sdmd_rdreq_t;

	function automatic logic [CNT_BITS-1:0] code_len(input sdmd_op_t op);
		logic [CNT_BITS-1:0] len;
		case (op)
			OP_ADVANCE: len = CNT_BITS'(1);
			OP_TAB_D5:  len = CNT_BITS'(2);
			OP_TAB_D13: len = CNT_BITS'(3);
			OP_TAB_D29: len = CNT_BITS'(5);
			OP_TAB_D45: len = CNT_BITS'(7);
			OP_LIT_D5:  len = CNT_BITS'(9);
			OP_LIT_D21: len = CNT_BITS'(11);
			OP_LIT_D45: len = CNT_BITS'(14);
			default:    len = CNT_BITS'(1);
		endcase
		return len;
	endfunction

endpackage

### hw/rtl/sdmd_vtab_mem.sv
// Value table memory: one write port, one registered read port.
// Depends on sdmd_pkg.
`timescale 1ns / 1ps

module sdmd_vtab_mem #(
	parameter int ENTRIES = sdmd_pkg::TAB_ENTRIES
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [7:0]                 wr_addr,
	input  logic [sdmd_pkg::VAL_BITS-1:0] wr_data,
	input  sdmd_pkg::sdmd_rdreq_t      rd,
	output logic [sdmd_pkg::VAL_BITS-1:0] rd_data
);
	import sdmd_pkg::*;

	localparam int AW = $clog2(ENTRIES);

	logic [VAL_BITS-1:0] vtab_q [ENTRIES];
	logic [VAL_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			vtab_q[wr_addr[AW-1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q <= vtab_q[rd.addr[AW-1:0]];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hw/rtl/sdmd_parse.sv
// Code assembly and position state: collects stream bytes, decodes complete codes.
// Depends on sdmd_pkg.
`timescale 1ns / 1ps

module sdmd_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  sdmd_pkg::sdmd_in_t    req,
	output logic                  hit_valid,
	output sdmd_pkg::sdmd_hit_t   hit,
	output sdmd_pkg::sdmd_rdreq_t rdreq
);
	import sdmd_pkg::*;

	logic [7:0]          code_q [CODE_MAX];
	logic [CNT_BITS-1:0] byte_count_q;
	logic [GROW_BITS-1:0] group_row_q;
	logic [POS_BITS-1:0] column_q;
	logic [POS_BITS-1:0] group_cnt_q;
	logic [POS_BITS-1:0] row_offset_q;

	logic [7:0]          cur [CODE_MAX];
	sdmd_op_t            op;
	logic [CNT_BITS-1:0] cnt_inc;
	logic                is_code;
	logic                done;
	logic [DELTA_BITS-1:0] delta;
	logic [GROW_BITS:0]  row_sum;
	logic [POS_BITS-1:0] col_next;
	logic                use_table;

	// view of the code with the arriving byte merged in
	always_comb begin
		for (int k = 0; k < CODE_MAX; k++) begin
			cur[k] = (byte_count_q == CNT_BITS'(k)) ? req.data_byte : code_q[k];
		end
	end

	assign op      = sdmd_op_t'(cur[0][2:0]);
	assign cnt_inc = byte_count_q + CNT_BITS'(1);
	assign is_code = (req.cmd == CMD_STREAM);
	assign done    = is_code && (cnt_inc >= code_len(op));

	always_comb begin
		case (op)
			OP_TAB_D13: delta = DELTA_BITS'({cur[2], cur[0][7:3]});
			OP_TAB_D29: delta = DELTA_BITS'({cur[4], cur[3], cur[2], cur[0][7:3]});
			OP_TAB_D45: delta = {cur[6], cur[5], cur[4], cur[3], cur[2], cur[0][7:3]};
			OP_LIT_D21: delta = DELTA_BITS'({cur[10], cur[9], cur[0][7:3]});
			OP_LIT_D45: delta = {cur[13], cur[12], cur[11], cur[10], cur[9], cur[0][7:3]};
			default:    delta = DELTA_BITS'(cur[0][7:3]);
		endcase
	end

	assign use_table = (op == OP_TAB_D5) || (op == OP_TAB_D13) ||
		(op == OP_TAB_D29) || (op == OP_TAB_D45);

	// row carry past the group bumps the column by one
	assign row_sum  = {1'b0, group_row_q} + {1'b0, delta[GROW_BITS-1:0]};
	assign col_next = column_q + POS_BITS'(row_sum[GROW_BITS])
		+ POS_BITS'(delta[DELTA_BITS-1:GROW_BITS]);

	assign hit_valid     = done && (op != OP_ADVANCE);
	assign hit.row_base  = {group_cnt_q[POS_BITS-GROW_BITS-1:0], row_sum[GROW_BITS-1:0]};
	assign hit.offset    = row_offset_q;
	assign hit.col       = col_next;
	assign hit.literal   = {cur[8], cur[7], cur[6], cur[5], cur[4], cur[3], cur[2], cur[1]};
	assign hit.use_table = use_table;

	assign rdreq.en   = accept && hit_valid && use_table;
	assign rdreq.addr = cur[1];

	always_ff @(posedge clk) begin
		if (accept && is_code) begin
			code_q[byte_count_q] <= req.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			group_row_q  <= '0;
			column_q     <= '0;
			group_cnt_q  <= '0;
			row_offset_q <= '0;
		end else if (accept && is_code) begin
			if (req.end_of_block) begin
				// drop any partial code, restart the block
				byte_count_q <= '0;
				group_row_q  <= '0;
				column_q     <= '0;
				group_cnt_q  <= '0;
				row_offset_q <= row_offset_q + req.block_rows;
			end else if (done) begin
				byte_count_q <= '0;
				if (op == OP_ADVANCE) begin
					group_cnt_q <= group_cnt_q + POS_BITS'(1);
					group_row_q <= '0;
					column_q    <= '0;
				end else begin
					group_row_q <= row_sum[GROW_BITS-1:0];
					column_q    <= col_next;
				end
			end else begin
				byte_count_q <= cnt_inc;
			end
		end
	end

endmodule

### hw/rtl/sparse_delta_matrix_decoder.sv
// Top level of the sparse delta matrix decoder: handshake, result stages, assertions.
// Depends on sdmd_pkg, sdmd_parse, sdmd_vtab_mem and the decoder defines header.
`timescale 1ns / 1ps
`include "sparse_delta_matrix_decoder_defines.svh"

// Sparse delta matrix decoder.
// Input channel req_valid/req_ready/req carries one request per cycle: with
// cmd = CMD_STREAM a byte of the code stream (end_of_block marks the last byte
// of a block, block_rows is then added to the row offset); with cmd = CMD_TABLE
// a write of table_value into value table entry table_index.
// Output channel res_valid/res_ready/res carries one decoded nonzero (global
// row, column, raw value bits) for each completed code with opcode 1 to 7.
// Throughput: one request per cycle while req_ready is high. The result for
// the request that completes the code passes through stage 1 and the output
// register before it shows on res_valid; the table read of the value memory
// is registered with stage 1, the row offset add with the output register.
// Stall: while the output register holds an untaken result, requests still
// enter as long as the middle stage is empty; once both are full, req_ready
// drops until res_ready frees the output register.
// Reset: position state, block state and both result stages clear at once;
// the value table is not cleared, so entries must be loaded before use.
module sparse_delta_matrix_decoder #(
	parameter int TABLE_ENTRIES = sdmd_pkg::TAB_ENTRIES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  sdmd_pkg::sdmd_in_t  req,
	output logic                res_valid,
	input  logic                res_ready,
	output sdmd_pkg::sdmd_out_t res
);
	import sdmd_pkg::*;

	logic        accept;
	logic        can_adv;
	logic        hit_valid;
	sdmd_hit_t   hit;
	sdmd_rdreq_t rdreq;
	logic [VAL_BITS-1:0] rd_data;

	logic        valid_s1;
	sdmd_hit_t   hit_s1;
	logic        out_valid_q;
	sdmd_out_t   out_q;

	// middle stage may move on when the output register is empty or drained
	assign can_adv   = !out_valid_q || res_ready;
	assign req_ready = !valid_s1 || can_adv;
	assign accept    = req_valid && req_ready;

	sdmd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req       (req),
		.hit_valid (hit_valid),
		.hit       (hit),
		.rdreq     (rdreq)
	);

	// table writes and reads never fall in the same cycle: each needs an accepted request, of cmd CMD_TABLE and CMD_STREAM
	sdmd_vtab_mem #(
		.ENTRIES (TABLE_ENTRIES)
	) u_vtab (
		.clk     (clk),
		.wr_en   (accept && (req.cmd == CMD_TABLE)),
		.wr_addr (req.table_index),
		.wr_data (req.table_value),
		.rd      (rdreq),
		.rd_data (rd_data)
	);

	// stage 1: decoded nonzero waits here while the table read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= hit_valid;
		end else if (can_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hit_valid) begin
			hit_s1 <= hit;
		end
	end

	// output register: add the row offset, pick table or literal value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (can_adv && valid_s1) begin
			out_q.row_index  <= hit_s1.row_base + hit_s1.offset;
			out_q.col_index  <= hit_s1.col;
			out_q.value_bits <= hit_s1.use_table ? rd_data : hit_s1.literal;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	`SDMD_ASSERT_NEXT(a_hit_enters_s1, accept && hit_valid, valid_s1, "decoded nonzero lost before stage 1")
	`SDMD_ASSERT_NEXT(a_table_write_no_result, accept && (req.cmd == CMD_TABLE), !valid_s1, "table write produced a result")
	`SDMD_ASSERT_NEXT(a_s1_drains, valid_s1 && !out_valid_q, out_valid_q, "stage 1 failed to move into an empty output register")
	`SDMD_ASSERT_NOW(a_stall_blocks_input, valid_s1 && out_valid_q && !res_ready, !req_ready, "request taken while both result stages are full")

endmodule

### bench/sparse_delta_matrix_decoder_test.sv
// Self-checking bench for the sparse delta matrix decoder: code streams, table loads
// and block ends checked against an in-bench decode of the same requests.
// Depends on sdmd_pkg and the sparse_delta_matrix_decoder RTL.
`timescale 1ns / 1ps

module sparse_delta_matrix_decoder_test;
	import sdmd_pkg::*;

	localparam int PERIOD       = 4;
	localparam int RESET_CYCLES = 5;
	localparam int STREAM_ITEMS = 1650;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 16;
	localparam int PRINT_CAP    = 200;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	sdmd_in_t  req;
	logic      res_valid;
	logic      res_ready;
	sdmd_out_t res;

	sparse_delta_matrix_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// Decode state mirrored in the bench: partial code, in-group row, column,
	// group count, row offset and the value table.
	logic [7:0]           code_buf [CODE_MAX];
	int                   code_fill;
	logic [GROW_BITS-1:0] grp_row;
	logic [POS_BITS-1:0]  col_pos;
	logic [POS_BITS-1:0]  grp_count;
	logic [POS_BITS-1:0]  row_base_off;
	logic [VAL_BITS-1:0]  value_store [TAB_ENTRIES];

	sdmd_out_t expected_nonzeros [$];
	sdmd_in_t  stream_requests [$];
	bit [TAB_ENTRIES-1:0] entry_loaded;

	bit req_fired;
	int req_gap;
	bit req_steady;
	int res_hold;
	bit res_steady;
	int mismatch_count;
	int cycle_count;

	task automatic note_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic int code_length(input sdmd_op_t op);
		int len;
		case (op)
			OP_ADVANCE: len = 1;
			OP_TAB_D5:  len = 2;
			OP_TAB_D13: len = 3;
			OP_TAB_D29: len = 5;
			OP_TAB_D45: len = 7;
			OP_LIT_D5:  len = 9;
			OP_LIT_D21: len = 11;
			OP_LIT_D45: len = 14;
			default:    len = 1;
		endcase
		return len;
	endfunction

	// Apply one accepted request to the mirrored state; queue the nonzero it yields.
	function automatic void decode_request(input sdmd_in_t r);
		sdmd_op_t             op;
		logic [47:0]          delta;
		logic [VAL_BITS-1:0]  val;
		logic [GROW_BITS:0]   row_sum;
		bit                   from_table;
		sdmd_out_t            hit;
		if (r.cmd == CMD_TABLE) begin
			// table writes ignore end_of_block
			value_store[r.table_index] = r.table_value;
		end else begin
			if (code_fill < CODE_MAX) begin
				code_buf[code_fill] = r.data_byte;
				code_fill++;
			end
			op = sdmd_op_t'(code_buf[0][2:0]);
			if (code_fill >= code_length(op)) begin
				code_fill = 0;
				if (op == OP_ADVANCE) begin
					grp_count = grp_count + 1'b1;
					grp_row = '0;
					col_pos = '0;
				end else begin
					delta = {43'b0, code_buf[0][7:3]};
					from_table = 1'b1;
					case (op)
						OP_TAB_D13: delta[12:5] = code_buf[2];
						OP_TAB_D29: delta[28:5] = {code_buf[4], code_buf[3], code_buf[2]};
						OP_TAB_D45: delta[44:5] = {code_buf[6], code_buf[5], code_buf[4],
							code_buf[3], code_buf[2]};
						OP_LIT_D5:  from_table = 1'b0;
						OP_LIT_D21: begin
							delta[20:5] = {code_buf[10], code_buf[9]};
							from_table = 1'b0;
						end
						OP_LIT_D45: begin
							delta[44:5] = {code_buf[13], code_buf[12], code_buf[11],
								code_buf[10], code_buf[9]};
							from_table = 1'b0;
						end
						default: ;
					endcase
					if (from_table)
						val = value_store[code_buf[1]];
					else
						val = {code_buf[8], code_buf[7], code_buf[6], code_buf[5],
							code_buf[4], code_buf[3], code_buf[2], code_buf[1]};
					// low delta nibble steps the row; a carry out of the group bumps the column
					row_sum = {1'b0, grp_row} + {1'b0, delta[3:0]};
					if (row_sum[GROW_BITS])
						col_pos = col_pos + 1'b1;
					grp_row = row_sum[GROW_BITS-1:0];
					col_pos = col_pos + (delta >> 4);
					hit.row_index = POS_BITS'(grp_row) + (grp_count << GROW_BITS) + row_base_off;
					hit.col_index = col_pos;
					hit.value_bits = val;
					expected_nonzeros.push_back(hit);
				end
			end
			// block end: drop any partial code, restart block state, advance the offset
			if (r.end_of_block) begin
				row_base_off = row_base_off + r.block_rows;
				code_fill = 0;
				grp_row = '0;
				col_pos = '0;
				grp_count = '0;
			end
		end
	endfunction

	function automatic logic [VAL_BITS-1:0] random_word();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		else if (pick == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	function automatic logic [DELTA_BITS-1:0] random_delta();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		else if (pick == 1)
			return '1;
		else if (pick < 5)
			return DELTA_BITS'($urandom_range(0, 63));
		return DELTA_BITS'({$urandom, $urandom});
	endfunction

	function automatic logic [POS_BITS-1:0] random_rows();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		else if (pick == 1)
			return '1;
		else if (pick < 6)
			return POS_BITS'($urandom_range(1, 1000));
		return POS_BITS'({$urandom, $urandom});
	endfunction

	// Gap before the next request: mostly none or short, now and then long.
	function automatic int next_gap(input bit steady);
		int pick;
		pick = $urandom_range(0, 99);
		if (steady || pick < 55)
			return 0;
		else if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Queue a table write; the stream fields carry noise, which the block must ignore.
	task automatic send_table(input logic [7:0] idx, input logic [VAL_BITS-1:0] val);
		sdmd_in_t it;
		it.cmd = CMD_TABLE;
		it.table_index = idx;
		it.table_value = val;
		it.data_byte = 8'($urandom);
		it.end_of_block = 1'($urandom);
		it.block_rows = POS_BITS'({$urandom, $urandom});
		stream_requests.push_back(it);
		entry_loaded[idx] = 1'b1;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic eob, input logic [POS_BITS-1:0] rows);
		sdmd_in_t it;
		it.cmd = CMD_STREAM;
		it.data_byte = b;
		it.end_of_block = eob;
		it.block_rows = rows;
		it.table_index = 8'($urandom);
		it.table_value = {$urandom, $urandom};
		stream_requests.push_back(it);
	endtask

	// Queue one code. payload is the table index (low byte) or the literal value.
	// cut > 0 stops after that many bytes; eob rides on the last byte sent.
	// mixed sprinkles table writes between the code bytes.
	task automatic send_code(input sdmd_op_t op, input logic [DELTA_BITS-1:0] delta,
			input logic [VAL_BITS-1:0] payload, input int cut, input logic eob,
			input logic [POS_BITS-1:0] rows, input bit mixed);
		logic [7:0]  b [CODE_MAX];
		logic [47:0] dx;
		int          n;
		int          first_delta;
		dx = {3'b0, delta};
		foreach (b[k])
			b[k] = 8'($urandom);
		b[0] = {delta[4:0], op};
		case (op)
			OP_TAB_D5, OP_TAB_D13, OP_TAB_D29, OP_TAB_D45: begin
				b[1] = payload[7:0];
				// load the entry before any code can read it
				if (!entry_loaded[payload[7:0]])
					send_table(payload[7:0], random_word());
				first_delta = 2;
			end
			OP_LIT_D5, OP_LIT_D21, OP_LIT_D45: begin
				for (int k = 0; k < 8; k++)
					b[1 + k] = payload[8 * k +: 8];
				first_delta = 9;
			end
			default: first_delta = CODE_MAX;
		endcase
		for (int k = 0; k < 5; k++)
			if (first_delta + k < CODE_MAX)
				b[first_delta + k] = dx[5 + 8 * k +: 8];
		n = (cut > 0 && cut < code_length(op)) ? cut : code_length(op);
		for (int k = 0; k < n; k++) begin
			if (mixed && k > 0 && $urandom_range(0, 15) == 0)
				send_table(8'($urandom), random_word());
			send_byte(b[k], eob && (k == n - 1), rows);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #(PERIOD / 2) clk = ~clk;
	end

	// Request side: note acceptance at the rising edge and feed the decode model.
	always @(posedge clk) begin
		req_fired <= arst_n && req_valid && req_ready;
		if (arst_n && req_valid && req_ready)
			decode_request(req);
	end

	// Request driver: advance at the falling edge once the held request is taken,
	// with random gaps and occasional stretches of back-to-back requests.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_fired) begin
			if (req_gap > 0) begin
				req_gap--;
				req_valid <= 1'b0;
			end else if (stream_requests.size() != 0) begin
				req <= stream_requests.pop_front();
				req_valid <= 1'b1;
				if ($urandom_range(0, 49) == 0)
					req_steady = !req_steady;
				req_gap = next_gap(req_steady);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure: hold ready low for short or long stalls, with
	// quiet stretches where ready stays high.
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0)
			res_steady = !res_steady;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (res_hold > 0) begin
			res_hold--;
			res_ready <= 1'b0;
		end else if (!res_steady && $urandom_range(0, 5) == 0) begin
			res_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	// Result monitor: match each taken nonzero against the oldest prediction.
	always @(posedge clk) begin : watch_results
		sdmd_out_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_nonzeros.size() == 0) begin
				note_mismatch($sformatf("unexpected nonzero row %h col %h value %h",
					res.row_index, res.col_index, res.value_bits));
			end else begin
				want = expected_nonzeros.pop_front();
				if (res.row_index !== want.row_index)
					note_mismatch($sformatf("row_index got %h want %h",
						res.row_index, want.row_index));
				if (res.col_index !== want.col_index)
					note_mismatch($sformatf("col_index got %h want %h",
						res.col_index, want.col_index));
				if (res.value_bits !== want.value_bits)
					note_mismatch($sformatf("value_bits got %h want %h",
						res.value_bits, want.value_bits));
			end
		end
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		sdmd_op_t op;
		int       pick;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		res_ready = 1'b0;
		code_fill = 0;
		grp_row = '0;
		col_pos = '0;
		grp_count = '0;
		row_base_off = '0;
		entry_loaded = '0;

		// Directed: table extremes, row carry out of the group, advance with
		// ignored upper bits, a truncated code at block end with the largest
		// row count, an all-ones literal, and a row that wraps past 48 bits.
		send_table(8'h00, '0);
		send_table(8'hFF, '1);
		send_code(OP_TAB_D5, 45'h1F, 64'hFF, 0, 1'b0, '0, 1'b0);
		send_code(OP_TAB_D5, 45'h1F, 64'hFF, 0, 1'b0, '0, 1'b0);
		send_code(OP_ADVANCE, '1, '0, 0, 1'b0, '0, 1'b0);
		send_code(OP_TAB_D13, '1, 64'h00, 0, 1'b0, '0, 1'b0);
		send_code(OP_TAB_D29, '1, 64'h00, 3, 1'b1, '1, 1'b0);
		send_code(OP_LIT_D5, '0, '1, 0, 1'b0, '0, 1'b0);
		send_code(OP_TAB_D5, 45'h3, 64'h00, 0, 1'b1, 48'h1, 1'b0);

		// Random: mostly well-formed codes with random content and block ends,
		// some truncated codes and stray table writes.
		while (stream_requests.size() < STREAM_ITEMS) begin
			pick = $urandom_range(0, 99);
			op = sdmd_op_t'(3'($urandom_range(0, 7)));
			if (pick < 8) begin
				send_table(8'($urandom), random_word());
			end else if (pick < 16) begin
				if (op == OP_ADVANCE)
					op = OP_TAB_D45;
				send_code(op, random_delta(), random_word(),
					$urandom_range(1, code_length(op) - 1), 1'b1, random_rows(), 1'b1);
			end else begin
				send_code(op, random_delta(), random_word(), 0,
					$urandom_range(0, 11) == 0, random_rows(), 1'b1);
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (stream_requests.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_nonzeros.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
